// File: design/iufp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU serial frame parser: shared package
// Frame geometry, header byte, checksum span and the types passed between
// the parser modules.
// ----------------------------------------------------------------------------
package iufp_pkg;

   localparam int unsigned FRAME_LEN = 19;
   localparam int unsigned FILL_W    = $clog2(FRAME_LEN + 1);

   localparam logic [7:0] HDR_BYTE = 8'hAA;

   // The checksum covers bytes SUM_FIRST through FRAME_LEN-2.
   localparam int unsigned SUM_FIRST = 2;
   localparam int unsigned SUM_TERMS = FRAME_LEN - 3;
   // Leaves of the checksum adder tree; covers the largest supported frame.
   localparam int unsigned SUM_SLOTS = 32;

   // Byte k of the window is element k; element 0 is the oldest byte.
   typedef logic [FRAME_LEN-1:0][7:0] window_type;

   typedef struct packed {
      logic [7:0]         frame_index;
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } result_type;

   typedef struct packed {
      logic       match;
      result_type result;
   } check_type;

endpackage
`default_nettype wire

// File: design/iufp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU serial frame parser: channel interfaces
// Valid/ready channels for received bytes and for decoded frames.
// ----------------------------------------------------------------------------
interface iufp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface iufp_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         frame_index;
   logic signed [15:0] yaw;
   logic signed [15:0] pitch;
   logic signed [15:0] roll;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;

   modport source (output valid, output frame_index, output yaw, output pitch,
                   output roll, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input frame_index, input yaw, input pitch,
                   input roll, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface
`default_nettype wire

// File: design/iufp_frame_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU serial frame parser: frame check
// Checks header and 8-bit sum of a full window and unpacks the fields.
// ----------------------------------------------------------------------------
module iufp_frame_check (
   input  iufp_pkg::window_type window,
   input  logic                 full,
   output iufp_pkg::check_type  check
);
   import iufp_pkg::*;

   logic [7:0] lvl0 [SUM_SLOTS];
   logic [7:0] lvl1 [SUM_SLOTS/2];
   logic [7:0] lvl2 [SUM_SLOTS/4];
   logic [7:0] lvl3 [SUM_SLOTS/8];
   logic [7:0] lvl4 [SUM_SLOTS/16];
   logic [7:0] sum;
   logic       hdr_ok;

   for (genvar k = 0; k < SUM_SLOTS; k++) begin : g_leaf
      if (k < SUM_TERMS) begin : g_term
         assign lvl0[k] = window[k + SUM_FIRST];
      end else begin : g_pad
         assign lvl0[k] = '0;
      end
   end

   // Balanced adder tree; the sum wraps at 8 bits.
   always_comb begin
      for (int i = 0; i < SUM_SLOTS/2; i++) lvl1[i] = lvl0[2*i] + lvl0[2*i+1];
      for (int i = 0; i < SUM_SLOTS/4; i++) lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
      for (int i = 0; i < SUM_SLOTS/8; i++) lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
      for (int i = 0; i < SUM_SLOTS/16; i++) lvl4[i] = lvl3[2*i] + lvl3[2*i+1];
      sum = lvl4[0] + lvl4[1];
   end

   assign hdr_ok = (window[0] == HDR_BYTE) && (window[1] == HDR_BYTE);

   always_comb begin
      check.match              = full && hdr_ok && (sum == window[FRAME_LEN-1]);
      check.result.frame_index = window[2];
      check.result.yaw         = signed'({window[4],  window[3]});
      check.result.pitch       = signed'({window[6],  window[5]});
      check.result.roll        = signed'({window[8],  window[7]});
      check.result.accel_x     = signed'({window[10], window[9]});
      check.result.accel_y     = signed'({window[12], window[11]});
      check.result.accel_z     = signed'({window[14], window[13]});
   end

endmodule
`default_nettype wire

// File: design/iufp_rsp_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU serial frame parser: result buffer
// Output register plus one skid entry, so a stalled receiver does not stop
// the byte stream until a second frame is waiting.
// ----------------------------------------------------------------------------
module iufp_rsp_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  iufp_pkg::result_type push_data,
   output logic                 push_ready,
   output logic                 out_valid,
   output iufp_pkg::result_type out_data,
   input  logic                 out_ready
);
   import iufp_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_data_ff, main_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push_valid;
            main_data_in  = push_data;
         end
      end else if (push_valid) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held while output register is empty");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("result pushed into a full buffer");

   a_skid_refills_main: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid entry lost on pop");

endmodule
`default_nettype wire

// File: design/imu_uart_frame_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IMU serial frame parser
// Slides a window over received bytes and emits one decoded frame per
// valid header-and-checksum match.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one received serial byte per item. rsp_bus carries one
//   decoded frame: index byte, yaw/pitch/roll in 0.01 degree and accel x/y/z
//   in 0.001 g, raw signed little-endian values.
//   A byte is taken every cycle while req_bus.ready is high. The byte that
//   completes a good frame produces a registered result on rsp_bus, behind
//   any result still held in the buffer; other bytes produce nothing.
//   Throughput is one byte per cycle while req_bus.ready is high, set by
//   the window shift and the checksum adder tree, both done in the accept cycle.
//   After a good frame the window counts as empty and needs a full frame
//   of new bytes before the next check.
//   Reset clears the fill count and the result buffer; the window bytes
//   themselves are not cleared.
//   If the receiver stalls, the result waits in the output register and a
//   second frame goes to a skid entry; req_bus.ready drops only while that
//   skid entry is occupied.
// ----------------------------------------------------------------------------
module imu_uart_frame_parser_core (
   input  logic       clock,
   input  logic       reset,
   iufp_req_if.sink   req_bus,
   iufp_rsp_if.source rsp_bus
);
   import iufp_pkg::*;

   window_type        window_ff, window_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] fill_next;
   logic              full;
   logic              accept;
   logic              push_valid;
   logic              push_ready;
   check_type         check;
   result_type        out_data;

   assign accept    = req_bus.valid && req_bus.ready;
   assign window_in = {req_bus.rx_byte, window_ff[FRAME_LEN-1:1]};
   assign fill_next = (fill_ff >= FILL_W'(FRAME_LEN)) ? FILL_W'(FRAME_LEN)
                                                      : fill_ff + FILL_W'(1);
   assign full      = (fill_next == FILL_W'(FRAME_LEN));

   iufp_frame_check u_check (
      .window (window_in),
      .full   (full),
      .check  (check)
   );

   assign push_valid = accept && check.match;

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         fill_in = check.match ? '0 : fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      if (accept) begin
         window_ff <= window_in;
      end
   end

   iufp_rsp_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (check.result),
      .push_ready (push_ready),
      .out_valid  (rsp_bus.valid),
      .out_data   (out_data),
      .out_ready  (rsp_bus.ready)
   );

   assign req_bus.ready       = push_ready;
   assign rsp_bus.frame_index = out_data.frame_index;
   assign rsp_bus.yaw         = out_data.yaw;
   assign rsp_bus.pitch       = out_data.pitch;
   assign rsp_bus.roll        = out_data.roll;
   assign rsp_bus.accel_x     = out_data.accel_x;
   assign rsp_bus.accel_y     = out_data.accel_y;
   assign rsp_bus.accel_z     = out_data.accel_z;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FRAME_LEN))
      else $error("fill count beyond frame length");

   a_match_empties: assert property (@(posedge clock) disable iff (reset)
      push_valid |=> (fill_ff == '0))
      else $error("window not emptied after a good frame");

   a_match_needs_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (fill_ff >= FILL_W'(FRAME_LEN - 1)))
      else $error("frame matched before the window was full");

endmodule
`default_nettype wire
